// ===== hdl/dti_pkg.sv =====
// Shared types and constants of the decision tree inference unit.
`timescale 1ns / 1ps
package dti_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 10;
  localparam int FEAT_W  = 6;
  localparam int VAL_W   = 32;
  localparam int CLS_W   = 8;
  localparam int LIMIT_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd32;

  typedef enum logic [OP_W-1:0] {
    OP_NODE_WR  = 2'd0,
    OP_FEAT_WR  = 2'd1,
    OP_CLASSIFY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NODE,
    ST_FEAT,
    ST_DONE
  } state_t;

  // Node entry without its class; the class width is a top-level parameter.
  typedef struct packed {
    logic              leaf;
    logic [FEAT_W-1:0] feature;
    logic [VAL_W-1:0]  threshold;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
  } node_split_t;

endpackage

// ===== hdl/dti_node_mem.sv =====
// Node memory: one write port, one registered read port.
`timescale 1ns / 1ps
module dti_node_mem
  import dti_pkg::*;
#(
  parameter int NODE_COUNT = 1024,
  parameter int CLASS_BITS = 8,
  parameter int NODE_AW    = 10
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [NODE_AW-1:0]    wr_addr,
  input  node_split_t           wr_split,
  input  logic [CLASS_BITS-1:0] wr_cls,
  input  logic                  rd_en,
  input  logic [NODE_AW-1:0]    rd_addr,
  output node_split_t           rd_split,
  output logic [CLASS_BITS-1:0] rd_cls
);

  node_split_t           split_mem [NODE_COUNT];
  logic [CLASS_BITS-1:0] cls_mem   [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      split_mem[wr_addr] <= wr_split;
      cls_mem[wr_addr]   <= wr_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_split <= split_mem[rd_addr];
      rd_cls   <= cls_mem[rd_addr];
    end
  end

endmodule

// ===== hdl/dti_feat_mem.sv =====
// Sample feature memory: one write port, one registered read port.
`timescale 1ns / 1ps
module dti_feat_mem
  import dti_pkg::*;
#(
  parameter int FEATURE_COUNT = 64,
  parameter int FEAT_AW       = 6
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [FEAT_AW-1:0] wr_addr,
  input  logic [VAL_W-1:0]   wr_data,
  input  logic               rd_en,
  input  logic [FEAT_AW-1:0] rd_addr,
  output logic [VAL_W-1:0]   rd_data
);

  logic [VAL_W-1:0] mem [FEATURE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/dti_step_unit.sv =====
// Shared split unit: signed feature/threshold compare and child select.
`timescale 1ns / 1ps
module dti_step_unit
  import dti_pkg::*;
(
  input  logic [VAL_W-1:0] value,
  input  logic [VAL_W-1:0] threshold,
  input  logic [IDX_W-1:0] left,
  input  logic [IDX_W-1:0] right,
  output logic [IDX_W-1:0] child
);

  logic go_left;

  // strictly below goes left, equal or above goes right
  assign go_left = $signed(value) < $signed(threshold);
  assign child   = go_left ? left : right;

endmodule

// ===== hdl/decision_tree_inference_unit.sv =====
// Top level of the binary decision tree inference unit.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a node entry write,
//   a feature value write, or a classify request for the stored sample.
//   Output channel (out_valid/out_ready) returns one item per classify:
//   class and index of the leaf reached, label match flag, walk error flag.
//   Config channel (cfg_valid/cfg_ready/cfg_data) sets walk_limit; it is
//   always ready and must only be written while the unit is idle.
// Timing:
//   in_ready stays high for back-to-back writes.
//   A classify walks the tree with one node memory read and one feature
//   memory read per level, the two reads feeding the single compare unit;
//   a walk that reaches walk_limit levels without a leaf is cut off.
//   in_ready is low while the walk runs.
// Stall:
//   The result sits in an output register; the unit goes idle again and
//   accepts writes while it waits. A following classify finishes its walk
//   and holds in its done state until the output register is free.
// Reset:
//   Clears the sequencer and out_valid and sets walk_limit to 32. Node and
//   feature memories are not cleared; entries must be written before use.
module decision_tree_inference_unit
  import dti_pkg::*;
#(
  parameter int NODE_COUNT    = 1024,
  parameter int FEATURE_COUNT = 64,
  parameter int CLASS_BITS    = 8
) (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [IDX_W-1:0]   node_index,
  input  logic               node_leaf,
  input  logic [FEAT_W-1:0]  node_feature,
  input  logic [VAL_W-1:0]   node_threshold,
  input  logic [IDX_W-1:0]   left_child,
  input  logic [IDX_W-1:0]   right_child,
  input  logic [CLS_W-1:0]   leaf_class,
  input  logic [FEAT_W-1:0]  feature_index,
  input  logic [VAL_W-1:0]   feature_value,
  input  logic [CLS_W-1:0]   expected_label,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CLS_W-1:0]   predicted_class,
  output logic [IDX_W-1:0]   leaf_reached,
  output logic               label_match,
  output logic               walk_error,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int NODE_AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

  // sequencer state
  state_t             state, state_next;
  logic [IDX_W-1:0]   cur, cur_next;
  logic               cur_oor, cur_oor_next;    // current node beyond memory
  logic               feat_oor, feat_oor_next;  // tested feature beyond memory
  logic [LIMIT_W-1:0] steps, steps_next;
  logic [CLS_W-1:0]   exp_label, exp_label_next;
  logic [LIMIT_W-1:0] walk_limit;

  // finished result waiting for the output register
  logic [CLS_W-1:0]   res_cls, res_cls_next;
  logic [IDX_W-1:0]   res_leaf, res_leaf_next;
  logic               res_match, res_match_next;
  logic               res_err, res_err_next;
  logic               out_load;
  logic               out_valid_next;

  logic               in_acc;
  op_t                op;

  // memory ports
  logic                  node_wr_en;
  logic [NODE_AW-1:0]    node_wr_addr;
  node_split_t           node_wr_split;
  logic [CLASS_BITS-1:0] node_wr_cls;
  logic                  node_rd_en;
  logic [IDX_W-1:0]      node_rd_idx;
  logic [NODE_AW-1:0]    node_rd_addr;
  node_split_t           node_rd_split;
  logic [CLASS_BITS-1:0] node_rd_cls;

  logic                  feat_wr_en;
  logic [FEAT_AW-1:0]    feat_wr_addr;
  logic                  feat_rd_en;
  logic [FEAT_AW-1:0]    feat_rd_addr;
  logic [VAL_W-1:0]      feat_rd_data;

  // index width adaption (works for memories narrower or wider than ports)
  logic [NODE_AW+IDX_W-1:0]     node_wr_ext, node_rd_ext;
  logic [FEAT_AW+FEAT_W-1:0]    feat_wr_ext, feat_rd_ext;
  logic [CLASS_BITS+CLS_W-1:0]  wr_cls_ext, rd_cls_ext;

  // node entry as seen by the walk; an out-of-range child reads all zero
  node_split_t           node_view;
  logic [CLASS_BITS-1:0] cls_view;
  logic [CLS_W-1:0]      cls_out;
  logic [VAL_W-1:0]      fval;
  logic [IDX_W-1:0]      child;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign op        = op_t'(operation);

  // write side
  assign node_wr_ext  = {{NODE_AW{1'b0}}, node_index};
  assign node_wr_addr = node_wr_ext[NODE_AW-1:0];
  assign wr_cls_ext   = {{CLASS_BITS{1'b0}}, leaf_class};
  assign node_wr_cls  = wr_cls_ext[CLASS_BITS-1:0];
  assign node_wr_en   = in_acc && (op == OP_NODE_WR) && (32'(node_index) < NODE_COUNT);

  always_comb begin
    node_wr_split.leaf      = node_leaf;
    node_wr_split.feature   = node_feature;
    node_wr_split.threshold = node_threshold;
    node_wr_split.left      = left_child;
    node_wr_split.right     = right_child;
  end

  assign feat_wr_ext  = {{FEAT_AW{1'b0}}, feature_index};
  assign feat_wr_addr = feat_wr_ext[FEAT_AW-1:0];
  assign feat_wr_en   = in_acc && (op == OP_FEAT_WR) &&
                        (32'(feature_index) < FEATURE_COUNT);

  // read side
  assign node_rd_ext  = {{NODE_AW{1'b0}}, node_rd_idx};
  assign node_rd_addr = node_rd_ext[NODE_AW-1:0];
  assign node_view    = cur_oor ? '0 : node_rd_split;
  assign cls_view     = cur_oor ? '0 : node_rd_cls;
  assign rd_cls_ext   = {{CLS_W{1'b0}}, cls_view};
  assign cls_out      = rd_cls_ext[CLS_W-1:0];

  assign feat_rd_ext  = {{FEAT_AW{1'b0}}, node_view.feature};
  assign feat_rd_addr = feat_rd_ext[FEAT_AW-1:0];
  assign fval         = feat_oor ? '0 : feat_rd_data;

  dti_node_mem #(
    .NODE_COUNT (NODE_COUNT),
    .CLASS_BITS (CLASS_BITS),
    .NODE_AW    (NODE_AW)
  ) u_node_mem (
    .clk      (clk),
    .wr_en    (node_wr_en),
    .wr_addr  (node_wr_addr),
    .wr_split (node_wr_split),
    .wr_cls   (node_wr_cls),
    .rd_en    (node_rd_en),
    .rd_addr  (node_rd_addr),
    .rd_split (node_rd_split),
    .rd_cls   (node_rd_cls)
  );

  dti_feat_mem #(
    .FEATURE_COUNT (FEATURE_COUNT),
    .FEAT_AW       (FEAT_AW)
  ) u_feat_mem (
    .clk     (clk),
    .wr_en   (feat_wr_en),
    .wr_addr (feat_wr_addr),
    .wr_data (feature_value),
    .rd_en   (feat_rd_en),
    .rd_addr (feat_rd_addr),
    .rd_data (feat_rd_data)
  );

  dti_step_unit u_step (
    .value     (fval),
    .threshold (node_view.threshold),
    .left      (node_view.left),
    .right     (node_view.right),
    .child     (child)
  );

  // sequencer: IDLE -> (NODE -> FEAT)* -> NODE -> DONE -> IDLE
  always_comb begin
    state_next     = state;
    cur_next       = cur;
    cur_oor_next   = cur_oor;
    feat_oor_next  = feat_oor;
    steps_next     = steps;
    exp_label_next = exp_label;
    res_cls_next   = res_cls;
    res_leaf_next  = res_leaf;
    res_match_next = res_match;
    res_err_next   = res_err;
    node_rd_en     = 1'b0;
    node_rd_idx    = '0;
    feat_rd_en     = 1'b0;
    out_load       = 1'b0;
    out_valid_next = out_valid & ~out_ready;

    case (state)
      ST_IDLE: begin
        if (in_acc && (op == OP_CLASSIFY)) begin
          // fetch the root
          cur_next       = '0;
          cur_oor_next   = 1'b0;
          steps_next     = '0;
          exp_label_next = expected_label;
          node_rd_en     = 1'b1;
          node_rd_idx    = '0;
          state_next     = ST_NODE;
        end
      end
      ST_NODE: begin
        if (node_view.leaf) begin
          res_cls_next   = cls_out;
          res_leaf_next  = cur;
          res_match_next = (cls_out == exp_label);
          res_err_next   = 1'b0;
          state_next     = ST_DONE;
        end else if (steps >= walk_limit) begin
          res_cls_next   = '0;
          res_leaf_next  = '0;
          res_match_next = 1'b0;
          res_err_next   = 1'b1;
          state_next     = ST_DONE;
        end else begin
          feat_rd_en    = 1'b1;
          feat_oor_next = (32'(node_view.feature) >= FEATURE_COUNT);
          state_next    = ST_FEAT;
        end
      end
      ST_FEAT: begin
        // take the child chosen by the compare and fetch it
        cur_next     = child;
        cur_oor_next = (32'(child) >= NODE_COUNT);
        node_rd_en   = 1'b1;
        node_rd_idx  = child;
        steps_next   = steps + LIMIT_W'(1);
        state_next   = ST_NODE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      walk_limit <= LIMIT_RESET;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        walk_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    cur_oor   <= cur_oor_next;
    feat_oor  <= feat_oor_next;
    steps     <= steps_next;
    exp_label <= exp_label_next;
    res_cls   <= res_cls_next;
    res_leaf  <= res_leaf_next;
    res_match <= res_match_next;
    res_err   <= res_err_next;
    if (out_load) begin
      predicted_class <= res_cls;
      leaf_reached    <= res_leaf;
      label_match     <= res_match;
      walk_error      <= res_err;
    end
  end

endmodule
